// ===== src/frd_pkg.sv =====
// ----------------------------------------------------------------------------
// frd_pkg: shared types and constants of the reply frame deframer
// Frame marker bytes, frame positions and the beat type passed between stages.
// ----------------------------------------------------------------------------
package frd_pkg;

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 16;
    localparam int POS_W   = 4;

    localparam logic [BYTE_W-1:0] START_BYTE   = 8'h7E;
    localparam logic [BYTE_W-1:0] VERSION_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] LENGTH_BYTE  = 8'h06;
    localparam logic [BYTE_W-1:0] END_BYTE     = 8'hEF;

    // Position = number of frame bytes held so far; 0 means hunting.
    localparam logic [POS_W-1:0] POS_HUNT      = 4'd0;
    localparam logic [POS_W-1:0] POS_VERSION   = 4'd1;
    localparam logic [POS_W-1:0] POS_LENGTH    = 4'd2;
    localparam logic [POS_W-1:0] POS_TYPE      = 4'd3;
    localparam logic [POS_W-1:0] POS_VALUE_HI  = 4'd5;
    localparam logic [POS_W-1:0] POS_VALUE_LO  = 4'd6;
    localparam logic [POS_W-1:0] POS_CHECK_HI  = 4'd7;
    localparam logic [POS_W-1:0] POS_CHECK_LO  = 4'd8;
    localparam logic [POS_W-1:0] POS_END       = 4'd9;

    // Frame bytes two to seven feed the running sum.
    localparam logic [POS_W-1:0] SUM_FIRST_POS = 4'd1;
    localparam logic [POS_W-1:0] SUM_LAST_POS  = 4'd6;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } beat_t;

endpackage

// ===== src/frd_in_reg.sv =====
// ----------------------------------------------------------------------------
// frd_in_reg: receive byte input register
// Holds one received beat until the parser takes it.
// ----------------------------------------------------------------------------
module frd_in_reg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rx_valid,
    input  logic [frd_pkg::BYTE_W-1:0] rx_byte,
    output logic                      rx_stall,
    input  logic                      take,
    output frd_pkg::beat_t            beat
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [frd_pkg::BYTE_W-1:0] data_reg;
    logic                       accept;

    // Stall only while a held beat cannot move on this cycle.
    assign rx_stall = valid_reg && !take;
    assign accept   = rx_valid && !rx_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= rx_byte;
        end
    end

    assign beat.valid = valid_reg;
    assign beat.data  = data_reg;

endmodule

// ===== src/frd_parser.sv =====
// ----------------------------------------------------------------------------
// frd_parser: frame tracker, checksum and reply register
// Steps the frame position, keeps the running sum and byte stores, and loads
// the reply register when a complete frame passes its checks.
// ----------------------------------------------------------------------------
module frd_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  frd_pkg::beat_t              beat,
    output logic                        take,
    output logic                        reply_valid,
    input  logic                        reply_stall,
    output logic [frd_pkg::BYTE_W-1:0]  reply_type,
    output logic [frd_pkg::VALUE_W-1:0] reply_value
);

    logic [frd_pkg::POS_W-1:0]   pos_reg;
    logic [frd_pkg::POS_W-1:0]   pos_next;
    logic [frd_pkg::POS_W-1:0]   pos_eff;
    logic [frd_pkg::VALUE_W-1:0] sum_reg;
    logic [frd_pkg::VALUE_W-1:0] sum_next;
    logic [frd_pkg::BYTE_W-1:0]  type_reg;
    logic [frd_pkg::BYTE_W-1:0]  value_hi_reg;
    logic [frd_pkg::BYTE_W-1:0]  value_lo_reg;
    logic [frd_pkg::BYTE_W-1:0]  check_hi_reg;
    logic [frd_pkg::BYTE_W-1:0]  check_lo_reg;
    logic                        reply_valid_reg;
    logic                        reply_valid_next;
    logic [frd_pkg::BYTE_W-1:0]  reply_type_reg;
    logic [frd_pkg::VALUE_W-1:0] reply_value_reg;
    logic                        frame_good;
    logic [frd_pkg::BYTE_W-1:0]  b;

    assign b       = beat.data;
    // Hold only the end byte while a reply still waits; other bytes keep moving.
    assign take    = beat.valid
                  && !(pos_eff == frd_pkg::POS_END && reply_valid_reg && reply_stall);
    assign pos_eff = (pos_reg > frd_pkg::POS_END) ? frd_pkg::POS_HUNT : pos_reg;

    assign frame_good = (b == frd_pkg::END_BYTE)
                     && ((~sum_reg + 16'd1) == {check_hi_reg, check_lo_reg});

    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        if (take)
        begin
            pos_next = pos_eff + 4'd1;
            if (pos_eff >= frd_pkg::SUM_FIRST_POS && pos_eff <= frd_pkg::SUM_LAST_POS)
            begin
                sum_next = sum_reg + {8'd0, b};
            end
            unique case (pos_eff)
                frd_pkg::POS_HUNT:
                begin
                    sum_next = '0;
                    pos_next = (b == frd_pkg::START_BYTE) ? frd_pkg::POS_VERSION
                                                          : frd_pkg::POS_HUNT;
                end
                frd_pkg::POS_VERSION:
                    pos_next = (b == frd_pkg::VERSION_BYTE) ? frd_pkg::POS_LENGTH
                                                            : frd_pkg::POS_HUNT;
                frd_pkg::POS_LENGTH:
                    pos_next = (b == frd_pkg::LENGTH_BYTE) ? frd_pkg::POS_TYPE
                                                           : frd_pkg::POS_HUNT;
                frd_pkg::POS_END:
                    pos_next = frd_pkg::POS_HUNT;
                default:
                    ;
            endcase
        end
    end

    // Hold the reply until taken; load a new one only from an accepted frame.
    always_comb
    begin
        reply_valid_next = reply_valid_reg && reply_stall;
        if (take && pos_eff == frd_pkg::POS_END && frame_good)
        begin
            reply_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= frd_pkg::POS_HUNT;
            sum_reg         <= '0;
            reply_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg         <= pos_next;
            sum_reg         <= sum_next;
            reply_valid_reg <= reply_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            case (pos_eff)
                frd_pkg::POS_TYPE:     type_reg     <= b;
                frd_pkg::POS_VALUE_HI: value_hi_reg <= b;
                frd_pkg::POS_VALUE_LO: value_lo_reg <= b;
                frd_pkg::POS_CHECK_HI: check_hi_reg <= b;
                frd_pkg::POS_CHECK_LO: check_lo_reg <= b;
                frd_pkg::POS_END:
                begin
                    if (frame_good)
                    begin
                        reply_type_reg  <= type_reg;
                        reply_value_reg <= {value_hi_reg, value_lo_reg};
                    end
                end
                default:
                    ;
            endcase
        end
    end

    assign reply_valid = reply_valid_reg;
    assign reply_type  = reply_type_reg;
    assign reply_value = reply_value_reg;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= frd_pkg::POS_END)
        else $error("frame position out of range");

    a_reply_from_end: assert property (@(posedge clk) disable iff (!rst_n)
        (reply_valid_next && !(reply_valid_reg && reply_stall))
            |-> (take && pos_eff == frd_pkg::POS_END))
        else $error("reply loaded outside the end byte");

    a_end_returns_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (take && pos_eff == frd_pkg::POS_END) |=> pos_reg == frd_pkg::POS_HUNT)
        else $error("end byte did not return to hunting");

    a_hunt_clears_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (take && pos_eff == frd_pkg::POS_HUNT) |=> sum_reg == '0)
        else $error("running sum not cleared while hunting");

endmodule

// ===== src/framed_reply_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// framed_reply_deframer_unit: 10-byte reply frame deframer
// Assembles 7E FF 06 reply frames from received bytes and emits good replies.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle with no gaps; a reply held back by its
// consumer stalls the input only once the end byte of the next frame is
// reached. A byte passes an input register and then the frame tracker, and
// the reply register loads once the tracker takes the end byte of its frame.
// Only frames with the correct header, a checksum equal to the negated
// 16-bit sum of bytes two to seven, and an 0xEF end byte produce a reply;
// any other frame is dropped without notice. A byte that breaks the header
// sends the block back to hunting and is not itself taken as a new start.
module framed_reply_deframer_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rx_valid,
    output logic                        rx_stall,
    input  logic [frd_pkg::BYTE_W-1:0]  rx_byte,
    output logic                        reply_valid,
    input  logic                        reply_stall,
    output logic [frd_pkg::BYTE_W-1:0]  reply_type,
    output logic [frd_pkg::VALUE_W-1:0] reply_value
);

    frd_pkg::beat_t beat;
    logic           take;

    frd_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_byte  (rx_byte),
        .rx_stall (rx_stall),
        .take     (take),
        .beat     (beat)
    );

    frd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .beat        (beat),
        .take        (take),
        .reply_valid (reply_valid),
        .reply_stall (reply_stall),
        .reply_type  (reply_type),
        .reply_value (reply_value)
    );

endmodule
